FILE: sv/pft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pft_pkg
// Shared codes, widths and cell control types of the PID filter table.
// ----------------------------------------------------------------------------
package pft_pkg;

  localparam int PID_W       = 13;
  localparam int FUNC_W      = 3;
  localparam int ENTRY_W     = 6;
  localparam int OUT_CNT_W   = 7;
  localparam int MAX_PIDS_DEF = 64;

  typedef logic [PID_W-1:0] pid_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP = 3'd0,
    FN_ADD    = 3'd1,
    FN_REMOVE = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  // Request broadcast to every cell in the accept cycle.
  typedef struct packed {
    logic               take;
    pid_t               pid;
    logic [ENTRY_W-1:0] entry_index;
  } cell_req_t;

  // Update command for one cell in the update cycle.
  typedef struct packed {
    logic load;
    logic shift;
    pid_t load_pid;
  } cell_upd_t;

endpackage : pft_pkg
`default_nettype wire

FILE: sv/pid_filter_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_filter_table
// Ordered list of distinct PIDs kept in a row of cells: lookup, add, remove,
// clear and read of one entry.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | func, pid, entry_index
//  out_    | output    | out_valid/out_stall| present, accepted, entry_count,
//          |           |                    | entry_pid
//
//  Each request has an accept cycle, where every cell compares its PID and
//  index at once, and an update cycle, where the list update (load, shift
//  down by one, count change) is done and the output register is loaded.
//  A stalled result holds the update cycle until the output is free.
//  Reset clears the count and the handshake state; cell contents are kept.
// ----------------------------------------------------------------------------
module pid_filter_table
  import pft_pkg::*;
#(
  parameter int MAX_PIDS = MAX_PIDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FUNC_W-1:0]    in_func,
  input  wire logic [PID_W-1:0]     in_pid,
  input  wire logic [ENTRY_W-1:0]   in_entry_index,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_present,
  output logic                      out_accepted,
  output logic [OUT_CNT_W-1:0]      out_entry_count,
  output logic [PID_W-1:0]          out_entry_pid
);

  localparam int CNT_W = $clog2(MAX_PIDS + 1);

  typedef enum logic {ST_IDLE, ST_UPDATE} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [FUNC_W-1:0]   func_r;
  pid_t                pid_r;
  logic                out_valid_r, out_valid_nxt;
  logic                present_r, present_nxt;
  logic                accepted_r, accepted_nxt;
  pid_t                epid_r, epid_nxt;

  logic                take;
  logic                fire;
  cell_req_t           req;
  cell_upd_t           upd [MAX_PIDS];
  pid_t                cell_pid [MAX_PIDS];
  logic [MAX_PIDS-1:0] hit_vec;
  logic [MAX_PIDS-1:0] sel_vec;
  logic [MAX_PIDS-1:0] shift_mask;
  logic                any_hit;
  pid_t                rd_pid;
  logic                do_load;
  logic                do_shift;
  logic                pid_nz;

  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && !in_stall;
  assign fire     = (state_r == ST_UPDATE) && (!out_valid_r || !out_stall);

  assign req.take        = take;
  assign req.pid         = in_pid;
  assign req.entry_index = in_entry_index;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PIDS; gi++) begin : g_cell
      pid_t nb_pid;
      if (gi == MAX_PIDS - 1) begin : g_last
        assign nb_pid = cell_pid[gi];
      end else begin : g_mid
        assign nb_pid = cell_pid[gi+1];
      end

      assign upd[gi].load     = do_load && (CNT_W'(gi) == count_r);
      assign upd[gi].shift    = do_shift && shift_mask[gi];
      assign upd[gi].load_pid = pid_r;

      pft_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk      (clk),
        .count    (count_r),
        .req      (req),
        .upd      (upd[gi]),
        .next_pid (nb_pid),
        .pid_q    (cell_pid[gi]),
        .hit_q    (hit_vec[gi]),
        .sel_q    (sel_vec[gi])
      );
    end
  endgenerate

  // Hit is one-hot; cells at and above it take their neighbor's PID.
  assign shift_mask = ~(hit_vec - MAX_PIDS'(1));
  assign any_hit    = |hit_vec;
  assign pid_nz     = (pid_r != '0);

  always_comb begin
    rd_pid = '0;
    for (int i = 0; i < MAX_PIDS; i++) begin
      rd_pid = rd_pid | (cell_pid[i] & {PID_W{sel_vec[i]}});
    end
  end

  always_comb begin
    present_nxt  = 1'b0;
    accepted_nxt = 1'b1;
    epid_nxt     = '0;
    count_nxt    = count_r;
    do_load      = 1'b0;
    do_shift     = 1'b0;
    case (func_r)
      FN_LOOKUP: begin
        present_nxt = pid_nz && any_hit;
      end
      FN_ADD: begin
        if (pid_nz) begin
          if (any_hit) begin
            present_nxt = 1'b1;
          end else if (count_r >= CNT_W'(MAX_PIDS)) begin
            accepted_nxt = 1'b0;
          end else begin
            do_load   = fire;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      FN_REMOVE: begin
        if (pid_nz && any_hit) begin
          present_nxt = 1'b1;
          do_shift    = fire;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      FN_CLEAR: begin
        count_nxt = '0;
      end
      FN_READ: begin
        epid_nxt = rd_pid;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // Request and result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      func_r <= in_func;
      pid_r  <= in_pid;
    end
    if (fire) begin
      present_r  <= present_nxt;
      accepted_r <= accepted_nxt;
      epid_r     <= epid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_present     = present_r;
  assign out_accepted    = accepted_r;
  assign out_entry_count = OUT_CNT_W'(count_r);
  assign out_entry_pid   = epid_r;

endmodule : pid_filter_table
`default_nettype wire

FILE: sv/pft_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pft_cell
// One list position: holds a PID, flags a match and a read select per request.
// ----------------------------------------------------------------------------
module pft_cell
  import pft_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire logic [CNT_W-1:0] count,
  input  wire cell_req_t        req,
  input  wire cell_upd_t        upd,
  input  wire pid_t             next_pid,
  output pid_t                  pid_q,
  output logic                  hit_q,
  output logic                  sel_q
);

  pid_t pid_r, pid_nxt;
  logic hit_r, hit_nxt;
  logic sel_r, sel_nxt;
  logic in_list;

  assign in_list = CNT_W'(IDX) < count;

  always_comb begin
    pid_nxt = pid_r;
    if (upd.load) begin
      pid_nxt = upd.load_pid;
    end else if (upd.shift) begin
      pid_nxt = next_pid;
    end
    hit_nxt = hit_r;
    sel_nxt = sel_r;
    if (req.take) begin
      hit_nxt = in_list && (pid_r == req.pid);
      sel_nxt = in_list && (32'(IDX) == 32'(req.entry_index));
    end
  end

  always_ff @(posedge clk) begin
    pid_r <= pid_nxt;
    hit_r <= hit_nxt;
    sel_r <= sel_nxt;
  end

  assign pid_q = pid_r;
  assign hit_q = hit_r;
  assign sel_q = sel_r;

endmodule : pft_cell
`default_nettype wire

FILE: test/pft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_checker
// Watches the request and result channels of pid_filter_table. It keeps its
// own copy of the PID list, works out the reply of every accepted request and
// compares each accepted result, field by field, with the oldest reply due.
// ----------------------------------------------------------------------------
module pft_checker
  import pft_pkg::*;
#(
  parameter int MAX_PIDS = MAX_PIDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [PID_W-1:0]     in_pid,
  input  logic [ENTRY_W-1:0]   in_entry_index,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_present,
  input  logic                 out_accepted,
  input  logic [OUT_CNT_W-1:0] out_entry_count,
  input  logic [PID_W-1:0]     out_entry_pid,
  output int                   mismatch_count,
  output int                   pending_count,
  output int                   result_count,
  output int                   full_reject_count,
  output int                   remove_hit_count
);

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    pid_t                 pid;
    logic [ENTRY_W-1:0]   entry_index;
    logic                 present;
    logic                 accepted;
    logic [OUT_CNT_W-1:0] entry_count;
    pid_t                 entry_pid;
  } pid_reply_t;

  pid_t        list_pids [MAX_PIDS];
  int unsigned list_len;
  pid_reply_t  due_replies [$];
  int          errors;
  int          seen;
  int          rejects;
  int          removes;

  // Apply one request to the local list and return the reply it should give.
  function automatic pid_reply_t apply_pid_request(logic [FUNC_W-1:0] f, pid_t p,
                                                   logic [ENTRY_W-1:0] idx);
    pid_reply_t r;
    int         pos;
    int         i;
    r             = '0;
    r.func        = f;
    r.pid         = p;
    r.entry_index = idx;
    r.accepted    = 1'b1;
    pos           = -1;
    if (p != '0) begin
      for (i = 0; i < int'(list_len); i++) begin
        if (pos < 0 && list_pids[i] == p) pos = i;
      end
    end
    case (f)
      FN_LOOKUP: r.present = (pos >= 0);
      FN_ADD: begin
        if (p != '0) begin
          if (pos >= 0) begin
            r.present = 1'b1;
          end else if (list_len >= MAX_PIDS) begin
            r.accepted = 1'b0;
          end else begin
            list_pids[list_len] = p;
            list_len++;
          end
        end
      end
      FN_REMOVE: begin
        if (pos >= 0) begin
          r.present = 1'b1;
          // close the gap, keep order
          for (i = pos; i + 1 < int'(list_len); i++) list_pids[i] = list_pids[i + 1];
          list_len--;
        end
      end
      FN_CLEAR: list_len = 0;
      FN_READ: begin
        if (idx < list_len) r.entry_pid = list_pids[idx];
      end
      default: ;
    endcase
    r.entry_count = list_len[OUT_CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pid_reply_t exp_reply;
    if (!rst_n) begin
      list_len = 0;
      due_replies.delete();
      errors  = 0;
      seen    = 0;
      rejects = 0;
      removes = 0;
    end else begin
      // compare before queuing, so a stray result never meets a fresh entry
      if (out_valid && !out_stall) begin
        seen++;
        if (due_replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("MISMATCH: result with nothing due: present %0b accepted %0b count %0d pid %0d",
                     out_present, out_accepted, out_entry_count, out_entry_pid);
        end else begin
          exp_reply = due_replies.pop_front();
          if (out_present !== exp_reply.present || out_accepted !== exp_reply.accepted ||
              out_entry_count !== exp_reply.entry_count ||
              out_entry_pid !== exp_reply.entry_pid) begin
            errors++;
            if (errors <= 10) begin
              $display("MISMATCH: func %0d pid %0d idx %0d", exp_reply.func, exp_reply.pid,
                       exp_reply.entry_index);
              $display("  expected present %0b accepted %0b count %0d pid %0d",
                       exp_reply.present, exp_reply.accepted, exp_reply.entry_count,
                       exp_reply.entry_pid);
              $display("  actual   present %0b accepted %0b count %0d pid %0d",
                       out_present, out_accepted, out_entry_count, out_entry_pid);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_reply = apply_pid_request(in_func, in_pid, in_entry_index);
        if (exp_reply.func == FN_ADD && !exp_reply.accepted) rejects++;
        if (exp_reply.func == FN_REMOVE && exp_reply.present) removes++;
        due_replies.push_back(exp_reply);
      end
    end
    mismatch_count    <= errors;
    pending_count     <= due_replies.size();
    result_count      <= seen;
    full_reject_count <= rejects;
    remove_hit_count  <= removes;
  end

endmodule : pft_checker

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives pid_filter_table with directed corner requests, then with random
// bulk loads, removals and mixed traffic under random idle and stall gaps;
// pft_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import pft_pkg::*;

  localparam int                LIMIT_CYCLES   = 1_000_000;
  localparam int                TARGET_OPS     = 1400;
  localparam int                POOL_SIZE      = 128;
  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = FUNC_W'(FN_READ + 1);
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = {FUNC_W{1'b1}};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func;
  logic [PID_W-1:0]     in_pid;
  logic [ENTRY_W-1:0]   in_entry_index;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_present;
  logic                 out_accepted;
  logic [OUT_CNT_W-1:0] out_entry_count;
  logic [PID_W-1:0]     out_entry_pid;

  int   mismatch_count;
  int   pending_count;
  int   result_count;
  int   full_reject_count;
  int   remove_hit_count;

  logic calm;
  int   stall_left;
  int   cycle_count;
  int   ops_sent;
  pid_t pid_pool [POOL_SIZE];

  pid_filter_table u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_pid          (in_pid),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_present     (out_present),
    .out_accepted    (out_accepted),
    .out_entry_count (out_entry_count),
    .out_entry_pid   (out_entry_pid)
  );

  pft_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_pid            (in_pid),
    .in_entry_index    (in_entry_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_present       (out_present),
    .out_accepted      (out_accepted),
    .out_entry_count   (out_entry_count),
    .out_entry_pid     (out_entry_pid),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .result_count      (result_count),
    .full_reject_count (full_reject_count),
    .remove_hit_count  (remove_hit_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  // Result side back-pressure: short bursts mostly, a few long ones.
  always @(posedge clk) begin
    int roll;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else if (roll < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(5, 40);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic pid_t pick_pid();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 20) return pid_t'($urandom);
    return pid_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Present one request and hold it until taken; valid stays high afterwards.
  task automatic send_request(logic [FUNC_W-1:0] f, pid_t p, logic [ENTRY_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_pid         <= p;
    in_entry_index <= idx;
    do @(posedge clk); while (in_stall);
    if (f <= FN_READ) ops_sent++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    int   k;
    int   n;
    int   start;
    int   roll;
    logic wide;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FN_LOOKUP;
    in_pid         <= '0;
    in_entry_index <= '0;
    calm           <= 1'b0;
    ops_sent = 0;
    // distinct nonzero pool: low bits carry the slot number
    for (k = 0; k < POOL_SIZE; k++) begin
      pid_pool[k] = pid_t'(($urandom_range(1, 63) << 7) | k);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: empty list, PID zero, duplicates, shifts, spare codes.
    send_request(FN_LOOKUP, '0, '0);
    send_request(FN_READ, '0, '0);
    send_request(FN_REMOVE, 13'd5, '0);
    send_request(FN_ADD, '0, '0);
    send_request(FN_REMOVE, '0, '0);
    send_request(FN_ADD, '1, '1);
    send_request(FN_ADD, 13'd1, '0);
    send_request(FN_ADD, '1, '0);
    send_request(FN_LOOKUP, '1, '0);
    send_request(FN_LOOKUP, '0, '0);
    send_request(FN_READ, '0, 6'd1);
    send_request(FN_READ, '0, '1);
    send_request(FN_ADD, 13'h0AAA, '0);
    send_request(FN_ADD, 13'h1555, '0);
    send_request(FN_REMOVE, '1, '0);
    for (k = 0; k < 3; k++) send_request(FN_READ, '1, ENTRY_W'(k));
    for (k = 0; k <= FN_SPARE_LAST - FN_SPARE_FIRST; k++) begin
      send_request(FUNC_W'(FN_SPARE_FIRST + k), '1, '1);
    end
    send_request(FN_CLEAR, '1, '1);
    send_request(FN_LOOKUP, 13'd1, '0);
    send_request(FN_READ, '0, '0);
    drain_replies();

    while (ops_sent < TARGET_OPS) begin
      calm <= ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(10, 40);
          for (k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 25)      send_request(FN_LOOKUP, pick_pid(), ENTRY_W'($urandom));
            else if (roll < 55) send_request(FN_ADD, pick_pid(), ENTRY_W'($urandom));
            else if (roll < 75) send_request(FN_REMOVE, pick_pid(), ENTRY_W'($urandom));
            else if (roll < 97) send_request(FN_READ, pid_t'($urandom),
                                             ENTRY_W'($urandom_range(0, roll[0] ? 63 : 15)));
            else                send_request(FN_CLEAR, pid_t'($urandom), ENTRY_W'($urandom));
          end
        end
        4, 5, 6: begin
          // bulk load: clear, a run of adds (often past full), read back
          wide  = ($urandom_range(0, 3) == 0);
          n     = ($urandom_range(0, 9) < 4) ? $urandom_range(60, 72) : $urandom_range(1, 59);
          start = $urandom_range(0, POOL_SIZE - 1);
          send_request(FN_CLEAR, pid_t'($urandom), ENTRY_W'($urandom));
          for (k = 0; k < n; k++) begin
            send_request(FN_ADD, wide ? pid_t'($urandom) : pid_pool[(start + k) % POOL_SIZE],
                         ENTRY_W'($urandom));
          end
          for (k = 0; k < n + 2 && k < 64; k++) begin
            send_request(FN_READ, pid_t'($urandom), ENTRY_W'(k));
          end
        end
        7: begin
          n     = $urandom_range(1, 40);
          start = $urandom_range(0, POOL_SIZE - 1);
          for (k = 0; k < n; k++) begin
            send_request(FN_REMOVE, pid_pool[(start + k) % POOL_SIZE], ENTRY_W'($urandom));
            if ($urandom_range(0, 2) == 0)
              send_request(FN_READ, pid_t'($urandom), ENTRY_W'($urandom_range(0, 8)));
          end
        end
        8: begin
          n = $urandom_range(1, 6);
          for (k = 0; k < n; k++) begin
            send_request(FUNC_W'(FN_LOOKUP + $urandom_range(0, FN_SPARE_LAST)),
                         pid_t'($urandom), ENTRY_W'($urandom));
          end
        end
        default: drain_replies();
      endcase
    end

    calm <= 1'b0;
    drain_replies();
    repeat (10) @(posedge clk);
    $display("Checked %0d results over %0d list requests;", result_count, ops_sent);
    $display("%0d adds refused on a full list, %0d removals closed a gap.",
             full_reject_count, remove_hit_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule : tb
